FILE: design/esd_pkg.sv
// ----------------------------------------------------------------------------
// esd_pkg
// Shared types and character constants for the C escape sequence decoder.
// ----------------------------------------------------------------------------
package esd_pkg;

	localparam int unsigned ByteW = 8;

	// Decoder phase codes
	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_BSL  = 3'd1,
		PH_HEX0 = 3'd2,
		PH_HEX1 = 3'd3,
		PH_OCT  = 3'd4
	} phase_t;

	typedef struct packed {
		phase_t             phase;
		logic [ByteW-1:0]   accum;
		logic [1:0]         digits;
	} dec_state_t;

	// Up to two results produced by one request
	typedef struct packed {
		logic [1:0]         cnt;
		logic [ByteW-1:0]   byte0;
		logic [ByteW-1:0]   byte1;
	} step_res_t;

	localparam logic [ByteW-1:0] CharBsl    = 8'h5c;
	localparam logic [ByteW-1:0] CharX      = 8'h78;
	localparam logic [ByteW-1:0] CharZero   = 8'h30;
	localparam logic [ByteW-1:0] CharSeven  = 8'h37;
	localparam logic [ByteW-1:0] CharNine   = 8'h39;
	localparam logic [ByteW-1:0] CharUpA    = 8'h41;
	localparam logic [ByteW-1:0] CharUpF    = 8'h46;
	localparam logic [ByteW-1:0] CharLowA   = 8'h61;
	localparam logic [ByteW-1:0] CharLowF   = 8'h66;
	localparam logic [ByteW-1:0] CharB      = 8'h62;
	localparam logic [ByteW-1:0] CharN      = 8'h6e;
	localparam logic [ByteW-1:0] CharR      = 8'h72;
	localparam logic [ByteW-1:0] CharT      = 8'h74;
	localparam logic [ByteW-1:0] CharV      = 8'h76;
	localparam logic [ByteW-1:0] CharQuote  = 8'h27;
	localparam logic [ByteW-1:0] CharDquote = 8'h22;
	localparam logic [ByteW-1:0] CharQmark  = 8'h3f;
	localparam logic [ByteW-1:0] CharNul    = 8'h00;
	localparam logic [ByteW-1:0] HexTen     = 8'h0a;

endpackage

FILE: design/esd_if.sv
// ----------------------------------------------------------------------------
// esd_in_if / esd_out_if
// Valid/ready byte channels for escaped text in and decoded bytes out.
// ----------------------------------------------------------------------------
interface esd_in_if;
	logic                      valid;
	logic                      ready;
	logic [esd_pkg::ByteW-1:0] in_byte;
	logic                      in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface esd_out_if;
	logic                      valid;
	logic                      ready;
	logic [esd_pkg::ByteW-1:0] out_byte;
	logic                      out_last;

	modport source (output valid, output out_byte, output out_last, input ready);
	modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

FILE: design/esd_step.sv
// ----------------------------------------------------------------------------
// esd_step
// Next-state and result logic for one text byte.
// ----------------------------------------------------------------------------
module esd_step (
	input  esd_pkg::dec_state_t        cur,
	input  logic [esd_pkg::ByteW-1:0]  in_byte,
	input  logic                       in_last,
	output esd_pkg::dec_state_t        nxt,
	output esd_pkg::step_res_t         res
);

	// Append one byte to the result pair
	function automatic esd_pkg::step_res_t push(esd_pkg::step_res_t r,
			logic [esd_pkg::ByteW-1:0] v);
		esd_pkg::step_res_t o;
		o = r;
		if (r.cnt == 2'd0) begin
			o.byte0 = v;
			o.cnt   = 2'd1;
		end else if (r.cnt == 2'd1) begin
			o.byte1 = v;
			o.cnt   = 2'd2;
		end
		return o;
	endfunction

	// {valid, value}
	function automatic logic [4:0] hex_val(logic [esd_pkg::ByteW-1:0] c);
		logic [esd_pkg::ByteW-1:0] d;
		d = '0;
		if (c >= esd_pkg::CharZero && c <= esd_pkg::CharNine) begin
			d = c - esd_pkg::CharZero;
			return {1'b1, d[3:0]};
		end else if (c >= esd_pkg::CharUpA && c <= esd_pkg::CharUpF) begin
			d = c - esd_pkg::CharUpA + esd_pkg::HexTen;
			return {1'b1, d[3:0]};
		end else if (c >= esd_pkg::CharLowA && c <= esd_pkg::CharLowF) begin
			d = c - esd_pkg::CharLowA + esd_pkg::HexTen;
			return {1'b1, d[3:0]};
		end
		return 5'd0;
	endfunction

	// {valid, mapped byte}
	function automatic logic [esd_pkg::ByteW:0] simple_esc(logic [esd_pkg::ByteW-1:0] c);
		logic [esd_pkg::ByteW:0] r;
		case (c)
			esd_pkg::CharLowA:   r = {1'b1, 8'h07};
			esd_pkg::CharB:      r = {1'b1, 8'h08};
			esd_pkg::CharLowF:   r = {1'b1, 8'h0c};
			esd_pkg::CharN:      r = {1'b1, 8'h0a};
			esd_pkg::CharR:      r = {1'b1, 8'h0d};
			esd_pkg::CharT:      r = {1'b1, 8'h09};
			esd_pkg::CharV:      r = {1'b1, 8'h0b};
			esd_pkg::CharBsl:    r = {1'b1, esd_pkg::CharBsl};
			esd_pkg::CharQuote:  r = {1'b1, esd_pkg::CharQuote};
			esd_pkg::CharDquote: r = {1'b1, esd_pkg::CharDquote};
			esd_pkg::CharQmark:  r = {1'b1, esd_pkg::CharQmark};
			esd_pkg::CharNul:    r = {1'b1, esd_pkg::CharNul};
			default:             r = '0;
		endcase
		return r;
	endfunction

	logic                      is_oct;
	logic [esd_pkg::ByteW-1:0] oct_d;
	logic [4:0]                hx;
	logic [esd_pkg::ByteW:0]   se;
	logic                      restart;
	logic [1:0]                digits_inc;

	assign is_oct     = (in_byte >= esd_pkg::CharZero) && (in_byte <= esd_pkg::CharSeven);
	assign oct_d      = in_byte - esd_pkg::CharZero;
	assign hx         = hex_val(in_byte);
	assign se         = simple_esc(in_byte);
	assign digits_inc = cur.digits + 2'd1;

	always_comb begin
		nxt     = cur;
		res     = '0;
		restart = 1'b0;
		case (cur.phase)
			esd_pkg::PH_BSL: begin
				if (se[esd_pkg::ByteW]) begin
					nxt.phase = esd_pkg::PH_IDLE;
					res       = push(res, se[esd_pkg::ByteW-1:0]);
				end else if (in_byte == esd_pkg::CharX) begin
					nxt.phase = esd_pkg::PH_HEX0;
				end else if (is_oct) begin
					nxt.accum  = oct_d;
					nxt.digits = 2'd1;
					nxt.phase  = esd_pkg::PH_OCT;
				end else begin
					// unknown escape: drop the backslash
					nxt.phase = esd_pkg::PH_IDLE;
					res       = push(res, in_byte);
				end
			end
			esd_pkg::PH_HEX0: begin
				if (hx[4]) begin
					nxt.accum = {4'd0, hx[3:0]};
					nxt.phase = esd_pkg::PH_HEX1;
				end else begin
					res     = push(res, esd_pkg::CharX);
					restart = 1'b1;
				end
			end
			esd_pkg::PH_HEX1: begin
				if (hx[4]) begin
					res       = push(res, {cur.accum[3:0], hx[3:0]});
					nxt.phase = esd_pkg::PH_IDLE;
				end else begin
					res     = push(res, cur.accum);
					restart = 1'b1;
				end
			end
			esd_pkg::PH_OCT: begin
				if (is_oct) begin
					nxt.accum  = {cur.accum[4:0], oct_d[2:0]};
					nxt.digits = digits_inc;
					if (digits_inc == 2'd3) begin
						res       = push(res, {cur.accum[4:0], oct_d[2:0]});
						nxt.phase = esd_pkg::PH_IDLE;
					end
				end else begin
					res     = push(res, cur.accum);
					restart = 1'b1;
				end
			end
			default: begin
				restart = 1'b1;
			end
		endcase

		// handle the byte as if no escape were pending
		if (restart) begin
			if (in_byte == esd_pkg::CharBsl) begin
				nxt.phase = esd_pkg::PH_BSL;
			end else begin
				nxt.phase = esd_pkg::PH_IDLE;
				res       = push(res, in_byte);
			end
		end

		// flush at end of string
		if (in_last) begin
			if (nxt.phase == esd_pkg::PH_HEX0) begin
				res = push(res, esd_pkg::CharX);
			end else if (nxt.phase == esd_pkg::PH_HEX1 || nxt.phase == esd_pkg::PH_OCT) begin
				res = push(res, nxt.accum);
			end
			nxt.phase = esd_pkg::PH_IDLE;
		end

		if (nxt.phase == esd_pkg::PH_IDLE) begin
			nxt.accum  = '0;
			nxt.digits = '0;
		end
	end

endmodule

FILE: design/escape_sequence_decoder.sv
// ----------------------------------------------------------------------------
// escape_sequence_decoder
// Decodes C-style escape sequences in a byte stream with end-of-string marks.
// ----------------------------------------------------------------------------
// The first result of a request is registered and valid in the cycle after acceptance.
// Throughput: one request per cycle while the output is ready; a request that
// yields two results holds intake while the second result drains from the
// two-entry result register.
// Reset: arst_n clears the decoder to idle with no escape pending and empties
// the result register.
module escape_sequence_decoder (
	input  logic              clk,
	input  logic              arst_n,
	esd_in_if.sink            text,
	esd_out_if.source         decoded
);

	esd_pkg::dec_state_t       state_q;
	esd_pkg::dec_state_t       state_nxt;
	esd_pkg::step_res_t        res;

	// Result register: slot 0 faces the output, slot 1 waits behind it
	logic [1:0]                fill_q;
	logic [esd_pkg::ByteW-1:0] byte0_q;
	logic [esd_pkg::ByteW-1:0] byte1_q;
	logic                      last0_q;
	logic                      last1_q;

	logic                      take;
	logic                      pop;

	esd_step u_step (
		.cur     (state_q),
		.in_byte (text.in_byte),
		.in_last (text.in_last),
		.nxt     (state_nxt),
		.res     (res)
	);

	assign pop            = decoded.valid && decoded.ready;
	// Accept when the result register is empty or its only entry leaves now
	assign text.ready     = (fill_q == 2'd0) || (fill_q == 2'd1 && decoded.ready);
	assign take           = text.valid && text.ready;

	assign decoded.valid    = (fill_q != 2'd0);
	assign decoded.out_byte = byte0_q;
	assign decoded.out_last = last0_q;

	// Decoder state and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: esd_pkg::PH_IDLE, accum: '0, digits: '0};
			fill_q  <= '0;
		end else begin
			if (take) begin
				state_q <= state_nxt;
				fill_q  <= res.cnt;
			end else if (pop) begin
				fill_q  <= fill_q - 2'd1;
			end
		end
	end

	// Result payload: load a new pair on intake, advance slot 1 on a pop
	always_ff @(posedge clk) begin
		if (take) begin
			byte0_q <= res.byte0;
			last0_q <= (res.cnt == 2'd1);
			byte1_q <= res.byte1;
			last1_q <= 1'b1;
		end else if (pop) begin
			byte0_q <= byte1_q;
			last0_q <= last1_q;
		end
	end

endmodule

FILE: tb/sv/tb_escape_sequence_decoder.sv
// ----------------------------------------------------------------------------
// tb_escape_sequence_decoder
// Self-checking bench for the C escape sequence decoder. A queue of text
// requests feeds a valid/ready driver, and a monitor on the same channels
// predicts every decoded byte in step with accepted requests and compares each
// delivered byte, with its end mark, against the oldest prediction. A short
// directed set of strings comes first, then randomly built escaped strings under four
// flow-control mixes.
// ----------------------------------------------------------------------------
module tb_escape_sequence_decoder;
	timeunit 1ns;
	timeprecision 1ps;

	import esd_pkg::*;

	// Cycles without any handshake before the run is declared hung
	localparam int unsigned StallLimit  = 2000;
	// Settling time after the last decoded byte
	localparam int unsigned DrainCycles = 20;
	// Random requests spread over the four flow-control phases
	localparam int unsigned RandomItems = 1330;

	typedef struct packed {
		logic [ByteW-1:0] data;
		logic             last;
	} marked_byte_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// Registered stimulus, known from time zero
	logic             drv_valid = 1'b0;
	logic [ByteW-1:0] drv_byte  = '0;
	logic             drv_last  = 1'b0;
	logic             rcv_ready = 1'b0;

	esd_in_if  text ();
	esd_out_if decoded ();

	assign text.valid    = drv_valid;
	assign text.in_byte  = drv_byte;
	assign text.in_last  = drv_last;
	assign decoded.ready = rcv_ready;

	escape_sequence_decoder u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.text    (text),
		.decoded (decoded)
	);

	// Pending text requests and predicted decoded bytes
	marked_byte_t text_q [$];
	marked_byte_t decoded_q [$];
	marked_byte_t next_want;

	// Predictor state, mirrors the decoder's phase, accumulator and digit count
	phase_t           dec_phase  = PH_IDLE;
	logic [ByteW-1:0] dec_accum  = '0;
	logic [1:0]       dec_digits = '0;

	logic [ByteW-1:0] simple_esc [12];

	logic        req_accepted = 1'b0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned idle_cycles = 0;
	int unsigned queued_count = 0;
	int unsigned req_count = 0;
	int unsigned result_count = 0;
	int unsigned pair_count = 0;
	int unsigned string_count = 0;
	int unsigned error_count = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		error_count++;
		// Keep the log bounded when the block is badly broken
		if (error_count <= 50) begin
			$display("[%0t] mismatch: %s", $time, msg);
		end
	endtask

	function automatic int hex_digit(input logic [ByteW-1:0] c);
		if (c >= CharZero && c <= CharNine) return int'(c - CharZero);
		if (c >= CharUpA && c <= CharUpF) return int'(c - CharUpA) + int'(HexTen);
		if (c >= CharLowA && c <= CharLowF) return int'(c - CharLowA) + int'(HexTen);
		return -1;
	endfunction

	function automatic logic is_octal(input logic [ByteW-1:0] c);
		return c >= CharZero && c <= CharSeven;
	endfunction

	// Advance the predictor by one accepted request and queue the bytes it
	// yields; the final byte of the request carries the end mark.
	function automatic void decode_byte(input logic [ByteW-1:0] b, input logic last);
		logic [ByteW-1:0] outs [2];
		logic [ByteW-1:0] esc_val;
		logic             esc_hit;
		logic             plain;
		int               n;
		int               hv;
		n = 0;
		plain = 1'b0;
		esc_hit = 1'b1;
		esc_val = '0;
		hv = hex_digit(b);
		case (dec_phase)
			PH_BSL: begin
				dec_phase = PH_IDLE;
				case (b)
					CharLowA: esc_val = 8'h07;
					CharB:    esc_val = 8'h08;
					CharLowF: esc_val = 8'h0c;
					CharN:    esc_val = HexTen;
					CharR:    esc_val = 8'h0d;
					CharT:    esc_val = 8'h09;
					CharV:    esc_val = 8'h0b;
					CharBsl, CharQuote, CharDquote, CharQmark, CharNul: esc_val = b;
					default:  esc_hit = 1'b0;
				endcase
				if (esc_hit) begin
					outs[n] = esc_val;
					n++;
				end else if (b == CharX) begin
					dec_phase = PH_HEX0;
				end else if (is_octal(b)) begin
					dec_accum = b - CharZero;
					dec_digits = 2'd1;
					dec_phase = PH_OCT;
				end else begin
					// Unknown escape: drop the backslash, keep the byte
					outs[n] = b;
					n++;
				end
			end
			PH_HEX0: begin
				if (hv >= 0) begin
					dec_accum = ByteW'(hv);
					dec_phase = PH_HEX1;
				end else begin
					// Bare \x yields a literal x before the byte is reprocessed
					outs[n] = CharX;
					n++;
					plain = 1'b1;
				end
			end
			PH_HEX1: begin
				if (hv >= 0) begin
					outs[n] = {dec_accum[3:0], 4'(hv)};
					n++;
					dec_phase = PH_IDLE;
				end else begin
					outs[n] = dec_accum;
					n++;
					plain = 1'b1;
				end
			end
			PH_OCT: begin
				if (is_octal(b)) begin
					// Shifting out the top bits truncates to one byte
					dec_accum = {dec_accum[4:0], b[2:0]};
					dec_digits = dec_digits + 2'd1;
					if (dec_digits == 2'd3) begin
						outs[n] = dec_accum;
						n++;
						dec_phase = PH_IDLE;
					end
				end else begin
					outs[n] = dec_accum;
					n++;
					plain = 1'b1;
				end
			end
			default: plain = 1'b1;
		endcase
		if (plain) begin
			if (b == CharBsl) begin
				dec_phase = PH_BSL;
			end else begin
				dec_phase = PH_IDLE;
				outs[n] = b;
				n++;
			end
		end
		// End of string flushes a pending value; a trailing backslash vanishes
		if (last) begin
			if (dec_phase == PH_HEX0) begin
				outs[n] = CharX;
				n++;
			end else if (dec_phase == PH_HEX1 || dec_phase == PH_OCT) begin
				outs[n] = dec_accum;
				n++;
			end
			dec_phase = PH_IDLE;
			string_count++;
		end
		if (dec_phase == PH_IDLE) begin
			dec_accum = '0;
			dec_digits = '0;
		end
		if (n == 2) pair_count++;
		for (int i = 0; i < n; i++) begin
			decoded_q.push_back(marked_byte_t'{outs[i], (i == n - 1)});
		end
	endfunction

	task automatic push_text(input logic [ByteW-1:0] b, input logic last);
		text_q.push_back(marked_byte_t'{b, last});
		queued_count++;
	endtask

	// Build one string from escape tokens: mostly well-formed escapes with
	// random content, plus raw bytes and stray backslashes as noise.
	task automatic add_random_string();
		logic [ByteW-1:0] seq [$];
		int               tokens;
		int               pick;
		tokens = $urandom_range(8, 1);
		for (int t = 0; t < tokens; t++) begin
			pick = $urandom_range(99);
			if (pick < 25) begin
				seq.push_back(ByteW'($urandom_range(255)));
			end else if (pick < 45) begin
				seq.push_back(CharBsl);
				seq.push_back(simple_esc[$urandom_range(11)]);
			end else if (pick < 65) begin
				seq.push_back(CharBsl);
				seq.push_back(CharX);
				repeat ($urandom_range(2)) begin
					case ($urandom_range(2))
						0:       seq.push_back(CharZero + ByteW'($urandom_range(9)));
						1:       seq.push_back(CharUpA + ByteW'($urandom_range(5)));
						default: seq.push_back(CharLowA + ByteW'($urandom_range(5)));
					endcase
				end
			end else if (pick < 85) begin
				seq.push_back(CharBsl);
				repeat ($urandom_range(3, 1)) begin
					seq.push_back(CharZero + ByteW'($urandom_range(7)));
				end
			end else if (pick < 93) begin
				seq.push_back(CharBsl);
				seq.push_back(ByteW'($urandom_range(255)));
			end else begin
				seq.push_back(CharBsl);
			end
		end
		foreach (seq[i]) begin
			push_text(seq[i], i == seq.size() - 1);
		end
	endtask

	// Hold until the driver is empty and every predicted byte has arrived
	task automatic wait_drained();
		do begin
			@(posedge clk);
		end while (text_q.size() != 0 || drv_valid || decoded_q.size() != 0);
	endtask

	// Driver: launch a new request once the current one was taken, with a
	// random chance of idling instead.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!drv_valid || req_accepted) begin
				if (text_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					drv_valid <= 1'b1;
					drv_byte  <= text_q[0].data;
					drv_last  <= text_q[0].last;
					text_q.pop_front();
				end else begin
					drv_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: drop ready at random to back-pressure the result register
	always @(negedge clk) begin
		rcv_ready <= arst_n && ($urandom_range(99) >= recv_stall_pct);
	end

	// Monitor: check delivered bytes first (they belong to earlier requests),
	// then predict the request accepted at this edge.
	always @(posedge clk) begin
		if (!arst_n) begin
			req_accepted <= 1'b0;
			idle_cycles = 0;
		end else begin
			req_accepted <= text.valid && text.ready;
			if (decoded.valid && decoded.ready) begin
				result_count++;
				if (decoded_q.size() == 0) begin
					report_mismatch($sformatf("unexpected byte %02h last %0b",
						decoded.out_byte, decoded.out_last));
				end else begin
					next_want = decoded_q.pop_front();
					if (decoded.out_byte !== next_want.data) begin
						report_mismatch($sformatf("out_byte %02h, predicted %02h",
							decoded.out_byte, next_want.data));
					end
					if (decoded.out_last !== next_want.last) begin
						report_mismatch($sformatf("out_last %0b, predicted %0b (byte %02h)",
							decoded.out_last, next_want.last, next_want.data));
					end
				end
			end
			if (text.valid && text.ready) begin
				req_count++;
				decode_byte(text.in_byte, text.in_last);
			end
			if ((text.valid && text.ready) || (decoded.valid && decoded.ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= StallLimit) begin
				$display("timeout: no handshake for %0d cycles", StallLimit);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		int unsigned target;
		simple_esc = '{CharLowA, CharB, CharLowF, CharN, CharR, CharT, CharV,
			CharBsl, CharQuote, CharDquote, CharQmark, CharNul};
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Byte extremes; the last mark on a plain byte
		push_text(CharNul, 1'b0);
		push_text(8'hff, 1'b1);
		// Simple escape
		push_text(CharBsl, 1'b0);
		push_text(CharN, 1'b0);
		// Full hex escape, mixed case digits
		push_text(CharBsl, 1'b0);
		push_text(CharX, 1'b0);
		push_text(CharUpF, 1'b0);
		push_text(CharLowF, 1'b0);
		// Three octal digits that overflow a byte
		push_text(CharBsl, 1'b0);
		push_text(CharSeven, 1'b0);
		push_text(CharSeven, 1'b0);
		push_text(CharSeven, 1'b0);
		// Bare \x followed by a non-hex letter
		push_text(CharBsl, 1'b0);
		push_text(CharX, 1'b0);
		push_text(8'h67, 1'b0);
		// Unknown escape
		push_text(CharBsl, 1'b0);
		push_text(8'h71, 1'b0);
		// Octal ended by a non-octal digit, which also ends the string
		push_text(CharBsl, 1'b0);
		push_text(CharZero + 8'd1, 1'b0);
		push_text(CharNine, 1'b1);
		// Hex value pending at end of string
		push_text(CharBsl, 1'b0);
		push_text(CharX, 1'b0);
		push_text(CharUpA, 1'b1);
		// Lone trailing backslash
		push_text(CharBsl, 1'b1);
		// Sender holds off here until every predicted byte is back
		wait_drained();

		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 88;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 88;
				end
				default: begin
					send_idle_pct = 16;
					recv_stall_pct = 16;
				end
			endcase
			target = queued_count + RandomItems / 4;
			while (queued_count < target) begin
				add_random_string();
			end
			wait_drained();
		end

		repeat (DrainCycles) @(posedge clk);
		if (decoded_q.size() != 0) begin
			report_mismatch($sformatf("%0d predicted bytes never delivered", decoded_q.size()));
		end

		$display("covered %0d requests in %0d strings, %0d decoded bytes (%0d double results),",
			req_count, string_count, result_count, pair_count);
		$display("under free flow, sender gaps, receiver stalls and mixed gaps; %0d mismatches",
			error_count);
		if (error_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

FILE: escape_sequence_decoder.f
design/esd_pkg.sv
design/esd_if.sv
design/esd_step.sv
design/escape_sequence_decoder.sv
tb/sv/tb_escape_sequence_decoder.sv
